/* sv/mmcs_pkg.sv */
// ---------------------------------------------------------------------------
// Min-max contrast stretch: shared package
// Types and constants used by the controller, the datapath and the top level.
// ---------------------------------------------------------------------------
package mmcs_pkg;

    // Q8.16 gain.
    localparam int GAIN_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int DIV_CNT_W  = $clog2(GAIN_W);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1 << FRAC_W);
    localparam logic [GAIN_W:0]   ROUND_HALF = (GAIN_W+1)'(1 << (FRAC_W - 1));

    // Configuration registers.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = CFG_IDX_W'(1);
    localparam logic [CFG_DATA_W-1:0] OUT_MIN_RESET = CFG_DATA_W'(0);
    localparam logic [CFG_DATA_W-1:0] OUT_MAX_RESET = CFG_DATA_W'(255);

    // Request kinds carried on tuser.
    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_APPLY   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic measure;        // take a measure word into the running extremes
        logic finish;         // last measure word: latch extremes, start divide
        logic div_step;       // one restoring divide step
        logic apply_capture;  // take an apply word into the product stage
        logic out_load;       // finish the apply word into the output register
    } mmcs_cmd_t;

    typedef struct packed {
        logic cnt_last;       // divider is on its final step
        logic out_free;       // output register can take a word this cycle
    } mmcs_status_t;

endpackage

/* sv/mmcs_ctrl.sv */
// ---------------------------------------------------------------------------
// Min-max contrast stretch: controller
// Sequences measure words, the per-frame gain division and apply words.
// ---------------------------------------------------------------------------
module mmcs_ctrl
    import mmcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         s_tready,
    input  mmcs_status_t status,
    output mmcs_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_APPLY) begin
                        state_next = ST_APPLY;
                    end else if (s_tlast) begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (status.cnt_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_APPLY: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == REQ_APPLY) begin
                        cmd.apply_capture = 1'b1;
                    end else begin
                        cmd.measure = 1'b1;
                        cmd.finish  = s_tlast;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_APPLY: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/mmcs_datapath.sv */
// ---------------------------------------------------------------------------
// Min-max contrast stretch: datapath
// Running extremes, restoring gain divider, product stage and output register.
// ---------------------------------------------------------------------------
module mmcs_datapath
    import mmcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mmcs_cmd_t              cmd,
    output mmcs_status_t           status,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_last,
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   out_flat,
    output logic                   out_last
);

    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = SB + GAIN_W;
    localparam int RND_W  = PROD_W + 1 - FRAC_W;
    localparam int Y_W    = RND_W + 1;
    localparam logic [SB-1:0] MAXVAL = '1;

    logic [CFG_DATA_W-1:0] out_min_reg, out_min_next;
    logic [CFG_DATA_W-1:0] out_max_reg, out_max_next;
    logic [SB-1:0]         run_low_reg, run_low_next;
    logic [SB-1:0]         run_high_reg, run_high_next;
    logic [SB-1:0]         frame_low_reg, frame_low_next;
    logic                  flat_reg, flat_next;
    logic [GAIN_W-1:0]     gain_reg, gain_next;
    logic [SB-1:0]         divisor_reg, divisor_next;
    logic [SB-1:0]         rem_reg, rem_next;
    logic [GAIN_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  hold_last_reg, hold_last_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SB-1:0]         out_sample_reg, out_sample_next;
    logic                  out_flat_reg, out_flat_next;
    logic                  out_last_reg, out_last_next;

    logic [SB-1:0]         new_low, new_high, diff;
    logic [CFG_DATA_W-1:0] span;
    logic [SB:0]           trial;
    logic                  fits;
    logic [GAIN_W-1:0]     quo_step;
    logic [PROD_W:0]       rounded;
    logic [RND_W-1:0]      rnd;
    logic [Y_W-1:0]        y;

    always_comb begin
        new_low  = (in_sample < run_low_reg)  ? in_sample : run_low_reg;
        new_high = (in_sample > run_high_reg) ? in_sample : run_high_reg;
        // An inverted target range collapses to a zero span.
        span  = (out_max_reg >= out_min_reg) ? (out_max_reg - out_min_reg) : '0;
        diff  = (in_sample > frame_low_reg) ? (in_sample - frame_low_reg) : '0;

        trial    = {rem_reg, quo_reg[GAIN_W-1]};
        fits     = (trial >= {1'b0, divisor_reg});
        quo_step = {quo_reg[GAIN_W-2:0], fits};

        rounded = {1'b0, prod_reg} + (PROD_W+1)'(ROUND_HALF);
        rnd     = rounded[PROD_W:FRAC_W];
        y       = Y_W'(rnd) + Y_W'(out_min_reg);
    end

    always_comb begin
        out_min_next = out_min_reg;
        out_max_next = out_max_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_OUT_MIN) begin
                out_min_next = cfg_data;
            end else if (cfg_index == CFG_OUT_MAX) begin
                out_max_next = cfg_data;
            end
        end

        run_low_next   = run_low_reg;
        run_high_next  = run_high_reg;
        frame_low_next = frame_low_reg;
        flat_next      = flat_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        gain_next      = gain_reg;
        if (cmd.measure) begin
            run_low_next  = new_low;
            run_high_next = new_high;
        end
        if (cmd.finish) begin
            // Latch the frame and restart the extremes for the next one.
            run_low_next   = MAXVAL;
            run_high_next  = '0;
            frame_low_next = new_low;
            flat_next      = (new_high <= new_low);
            divisor_next   = new_high - new_low;
            rem_next       = '0;
            quo_next       = {span, FRAC_W'(0)};
            cnt_next       = '0;
        end
        if (cmd.div_step) begin
            rem_next = fits ? SB'(trial - {1'b0, divisor_reg}) : trial[SB-1:0];
            quo_next = quo_step;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (status.cnt_last) begin
                gain_next = flat_reg ? '0 : quo_step;
            end
        end

        prod_next      = prod_reg;
        hold_last_next = hold_last_reg;
        if (cmd.apply_capture) begin
            prod_next      = PROD_W'(diff) * PROD_W'(gain_reg);
            hold_last_next = in_last;
        end

        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        out_flat_next   = out_flat_reg;
        out_last_next   = out_last_reg;
        if (cmd.out_load) begin
            out_valid_next  = 1'b1;
            out_sample_next = (y > Y_W'(MAXVAL)) ? MAXVAL : y[SB-1:0];
            out_flat_next   = flat_reg;
            out_last_next   = hold_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_min_reg   <= OUT_MIN_RESET;
            out_max_reg   <= OUT_MAX_RESET;
            run_low_reg   <= MAXVAL;
            run_high_reg  <= '0;
            frame_low_reg <= '0;
            flat_reg      <= 1'b0;
            gain_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            out_min_reg   <= out_min_next;
            out_max_reg   <= out_max_next;
            run_low_reg   <= run_low_next;
            run_high_reg  <= run_high_next;
            frame_low_reg <= frame_low_next;
            flat_reg      <= flat_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        divisor_reg    <= divisor_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        prod_reg       <= prod_next;
        hold_last_reg  <= hold_last_next;
        out_sample_reg <= out_sample_next;
        out_flat_reg   <= out_flat_next;
        out_last_reg   <= out_last_next;
    end

    assign status.cnt_last = (cnt_reg == DIV_CNT_W'(GAIN_W - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_flat   = out_flat_reg;
    assign out_last   = out_last_reg;

endmodule

/* sv/min_max_contrast_stretch_top.sv */
// ---------------------------------------------------------------------------
// Min-max contrast stretch: top level
// Each frame of one channel is streamed in twice. Measure words (tuser low)
// track the running minimum and maximum; the measure word with tlast set
// latches them and computes a Q8.16 gain (out_max - out_min) / (max - min).
// Apply words (tuser high) each give one output word, the sample stretched to
// run from out_min to out_max, with the flat flag on tuser and tlast copied.
// Measure words are taken one per cycle while s_tready is high and give no
// output. The last measure word is followed by the bit-serial gain divider,
// one quotient bit per cycle, during which s_tready is low. An apply word
// goes through a multiply stage, then the round, offset and clamp into the
// output register, loaded when that register is free, which raises m_tvalid.
// The output register lets one more apply word into the multiply stage while
// a result waits; a longer stall on m_tready then holds s_tready low.
// Configuration writes (index 0 out_min, index 1 out_max) are always taken,
// and belong in idle gaps between frames. Reset (aresetn low, synchronous)
// restores out_min 0, out_max 255, identity gain, minimum 0, and clears the
// running extremes.
// ---------------------------------------------------------------------------
module min_max_contrast_stretch_top
    import mmcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 8,
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // sample
    input  logic                  s_tuser,   // req_type
    input  logic                  s_tlast,   // last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // sample_out
    output logic                  m_tuser,   // flat
    output logic                  m_tlast,   // last_out
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    mmcs_cmd_t              cmd;
    mmcs_status_t           status;
    logic [SAMPLE_BITS-1:0] out_sample;

    assign cfg_ready = 1'b1;

    mmcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mmcs_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_last    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (out_sample),
        .out_flat   (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = TDATA_W'(out_sample);

endmodule

/* tb/tb_min_max_contrast_stretch_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Min-max contrast stretch: testbench
// Streams measure and apply passes through the block under randomized sender
// bursts and receiver stalls. Every accepted word goes through a local
// predictor of the stretch, and every output word is compared field by field
// with the oldest prediction. The out_min and out_max registers are reprogrammed
// between phases once the block has drained.
// ---------------------------------------------------------------------------
module tb_min_max_contrast_stretch_top;
    import mmcs_pkg::*;

    localparam int SAMPLE_BITS = 8;
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam logic [SAMPLE_BITS-1:0] MAXVAL = '1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD_CYCLES = 150;

    typedef struct packed {
        logic                   kind;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } sample_word_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   flat;
        logic                   last;
    } stretch_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    min_max_contrast_stretch_top #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sample_word_t  sample_q[$];
    stretch_word_t stretched_q[$];
    int            items_queued = 0;
    int            mismatches = 0;
    int            cycle_count = 0;
    int            long_stall_reqs = 0;
    int            long_stall_done = 0;
    logic          s_fire = 1'b0;
    logic          cfg_fire = 1'b0;

    // Predictor copy of the block's registers and frame state.
    logic [SAMPLE_BITS-1:0] tgt_min = OUT_MIN_RESET;
    logic [SAMPLE_BITS-1:0] tgt_max = OUT_MAX_RESET;
    logic [SAMPLE_BITS-1:0] run_low = MAXVAL;
    logic [SAMPLE_BITS-1:0] run_high = '0;
    logic [SAMPLE_BITS-1:0] lat_low = '0;
    logic [GAIN_W-1:0]      lat_gain = GAIN_RESET;
    logic                   lat_flat = 1'b0;

    // Folds one accepted word into the frame state; returns 1 with the
    // stretched word when the input is an apply word.
    function automatic bit stretch_predict(input sample_word_t w, output stretch_word_t r);
        logic [SAMPLE_BITS-1:0] span;
        logic [SAMPLE_BITS-1:0] delta;
        logic [63:0]            acc;
        r = '0;
        if (w.kind == REQ_MEASURE) begin
            if (w.sample < run_low) run_low = w.sample;
            if (w.sample > run_high) run_high = w.sample;
            if (w.last) begin
                // An inverted target collapses to a zero span.
                span = (tgt_max >= tgt_min) ? tgt_max - tgt_min : '0;
                lat_low = run_low;
                if (run_high <= run_low) begin
                    lat_flat = 1'b1;
                    lat_gain = '0;
                end else begin
                    lat_flat = 1'b0;
                    lat_gain = GAIN_W'((32'(span) << FRAC_W) / 32'(run_high - run_low));
                end
                run_low = MAXVAL;
                run_high = '0;
            end
            return 1'b0;
        end
        if (lat_flat) begin
            acc = 64'(tgt_min);
        end else begin
            delta = (w.sample > lat_low) ? w.sample - lat_low : '0;
            acc = 64'(tgt_min)
                + ((64'(delta) * 64'(lat_gain) + 64'(ROUND_HALF)) >> FRAC_W);
        end
        if (acc > 64'(MAXVAL)) acc = 64'(MAXVAL);
        r.value = acc[SAMPLE_BITS-1:0];
        r.flat = lat_flat;
        r.last = w.last;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatches < 40)
            $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    function automatic void push_word(input logic kind, input logic [SAMPLE_BITS-1:0] val,
                                      input logic last);
        sample_q.push_back('{kind, val, last});
        items_queued++;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] in_band(input int lo, input int w);
        int v;
        v = lo + $urandom_range(0, w);
        return (v > MAXVAL) ? MAXVAL : SAMPLE_BITS'(v);
    endfunction

    // One frame: a measure pass over a band of values, then an apply pass that
    // mostly stays in the band but also strays below and above it.
    function automatic void push_frame(input int n_meas, input int n_apply, input bit close_meas);
        int lo;
        int w;
        lo = $urandom_range(0, MAXVAL);
        case ($urandom_range(0, 3))
            0: w = 0;
            1: w = 1;
            2: w = $urandom_range(2, 40);
            default: w = MAXVAL;
        endcase
        for (int i = 0; i < n_meas; i++)
            push_word(REQ_MEASURE, in_band(lo, w), close_meas && (i == n_meas - 1));
        for (int i = 0; i < n_apply; i++)
            push_word(REQ_APPLY,
                      ($urandom_range(0, 9) < 7) ? in_band(lo, w) : SAMPLE_BITS'($urandom),
                      i == n_apply - 1);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued word is taken and every result has come back,
    // then lets a divide that produces no result run out.
    task automatic wait_drained();
        do @(posedge aclk); while (sample_q.size() != 0 || s_tvalid || stretched_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Sender: bursts of words separated by random gaps.
    int burst_left = 8;
    int gap_left = 0;
    always @(negedge aclk) begin
        sample_word_t w;
        logic         next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_fire)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (sample_q.size() != 0) begin
                w = sample_q.pop_front();
                s_tdata <= TDATA_W'(w.sample);
                s_tuser <= w.kind;
                s_tlast <= w.last;
                next_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: changes its stall pattern at random intervals, and holds
    // off completely for a long stretch when asked to.
    int hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_tick = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (long_stall_reqs != long_stall_done) begin
            long_stall_done++;
            hold_left = LONG_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(50, 300);
            end else begin
                rx_mode_left--;
            end
            rx_tick++;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    // Monitor: predicts on every accepted input word and checks every
    // accepted output word against the oldest prediction.
    always @(posedge aclk) begin
        stretch_word_t want;
        stretch_word_t got;
        if (!aresetn) begin
            s_fire   <= 1'b0;
            cfg_fire <= 1'b0;
        end else begin
            s_fire   <= s_tvalid && s_tready;
            cfg_fire <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_OUT_MIN: tgt_min = cfg_data;
                    CFG_OUT_MAX: tgt_max = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (stretch_predict('{s_tuser, s_tdata[SAMPLE_BITS-1:0], s_tlast}, want))
                    stretched_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[SAMPLE_BITS-1:0], m_tuser, m_tlast};
                if (stretched_q.size() == 0) begin
                    report_mismatch("output word with nothing expected", got.value, -1);
                end else begin
                    want = stretched_q.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("sample_out", got.value, want.value);
                    if (got.flat !== want.flat)
                        report_mismatch("flat", got.flat, want.flat);
                    if (got.last !== want.last)
                        report_mismatch("last_out", got.last, want.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("min_max_contrast_stretch_top: mismatch");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] new_min;
        logic [CFG_DATA_W-1:0] new_max;
        int                    phase_start;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Before any frame is measured the reset gain passes samples through.
        push_word(REQ_APPLY, 8'h00, 1'b0);
        push_word(REQ_APPLY, 8'hFF, 1'b0);
        push_word(REQ_APPLY, 8'h5A, 1'b1);
        // Full-range frame gives the identity gain.
        push_word(REQ_MEASURE, 8'h00, 1'b0);
        push_word(REQ_MEASURE, 8'hFF, 1'b0);
        push_word(REQ_MEASURE, 8'h11, 1'b1);
        push_word(REQ_APPLY, 8'h00, 1'b0);
        push_word(REQ_APPLY, 8'hFF, 1'b0);
        push_word(REQ_APPLY, 8'h64, 1'b1);
        // A flat frame, then a one-word measure pass, which is flat as well.
        push_word(REQ_MEASURE, 8'h4D, 1'b0);
        push_word(REQ_MEASURE, 8'h4D, 1'b1);
        push_word(REQ_APPLY, 8'h0A, 1'b0);
        push_word(REQ_APPLY, 8'hC8, 1'b1);
        push_word(REQ_MEASURE, 8'hAA, 1'b1);
        push_word(REQ_APPLY, 8'h00, 1'b1);
        wait_drained();

        // Inverted target: every apply word gives out_min.
        write_reg(CFG_OUT_MIN, 8'd200);
        write_reg(CFG_OUT_MAX, 8'd50);
        push_word(REQ_MEASURE, 8'h0A, 1'b0);
        push_word(REQ_MEASURE, 8'h5A, 1'b1);
        push_word(REQ_APPLY, 8'h05, 1'b0);
        push_word(REQ_APPLY, 8'h5A, 1'b1);
        wait_drained();

        // A range of one gives the largest gain, so samples above it saturate.
        write_reg(CFG_OUT_MIN, 8'd0);
        write_reg(CFG_OUT_MAX, 8'd255);
        push_word(REQ_MEASURE, 8'h64, 1'b0);
        push_word(REQ_MEASURE, 8'h65, 1'b1);
        push_word(REQ_APPLY, 8'h63, 1'b0);
        push_word(REQ_APPLY, 8'h65, 1'b0);
        push_word(REQ_APPLY, 8'hFF, 1'b1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin new_min = 8'd0;   new_max = 8'd255; end
                1: begin new_min = 8'd255; new_max = 8'd255; end
                2: begin new_min = 8'd0;   new_max = 8'd0;   end
                3: begin new_min = 8'd255; new_max = 8'd0;   end
                4: begin new_min = 8'd16;  new_max = 8'd240; end
                default: begin
                    new_min = CFG_DATA_W'($urandom_range(0, 255));
                    new_max = CFG_DATA_W'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_OUT_MIN, new_min);
            write_reg(CFG_OUT_MAX, new_max);
            phase_start = items_queued;
            if (p == 2 || p == 5) begin
                // Long apply pass while the receiver holds off.
                long_stall_reqs++;
                push_frame(6, 48, 1'b1);
            end
            while (items_queued - phase_start < 120) begin
                case ($urandom_range(0, 9))
                    0: push_word(1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom),
                                 1'($urandom_range(0, 1)));
                    // Measure pass left open, so its extremes carry into the next.
                    1: push_frame($urandom_range(1, 8), $urandom_range(1, 8), 1'b0);
                    default: push_frame(($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12),
                                        $urandom_range(1, 16), 1'b1);
                endcase
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("min_max_contrast_stretch_top: match");
        end else begin
            $display("min_max_contrast_stretch_top: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/mmcs_pkg.sv
sv/mmcs_ctrl.sv
sv/mmcs_datapath.sv
sv/min_max_contrast_stretch_top.sv
tb/tb_min_max_contrast_stretch_top.sv
